// ----- hw/rtl/uoi_pkg.sv -----
// ----------------------------------------------------------------------------
// uoi_pkg
// Shared types, constants and the arctangent table of the odometry integrator.
// ----------------------------------------------------------------------------
package uoi_pkg;

   // cordic iteration count, capped at the length of the arctangent table
   localparam int CORDIC_STEPS  = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_ITERS  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int IDX_W         = $clog2(CORDIC_ITERS);

   // fixed point constants
   localparam int PI_Q13        = 25736;
   localparam int TWO_PI_Q13    = 51472;
   localparam int HALF_PI_Q13   = 12868;
   localparam int CORDIC_GAIN   = 652032874;

   // configuration register map
   localparam int CSR_ADDR_W    = 2;
   localparam logic [CSR_ADDR_W-1:0] REG_TIME_STEP = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SMOOTHING = 2'd1;
   localparam logic [15:0] TIME_STEP_RESET = 16'd3277;
   localparam logic [15:0] SMOOTHING_RESET = 16'd6554;

   // operand selection for the shared multiplier
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_HEAD,
      MUL_DIST,
      MUL_LIN,
      MUL_ANG,
      MUL_XLO,
      MUL_XHI,
      MUL_YLO,
      MUL_YHI
   } mul_sel_type;

   // command word from controller to datapath
   typedef struct packed {
      mul_sel_type      mul_sel;
      logic             load_in;
      logic             head_upd;
      logic             cordic_init;
      logic             cordic_step;
      logic             lin_upd;
      logic             ang_upd;
      logic             dist_load;
      logic             lo_load;
      logic             x_upd;
      logic             y_upd;
      logic             out_load;
      logic [IDX_W-1:0] iter;
   } uoi_cmd_type;

   // arctangent of 2^-i in Q2.30
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'h3243F6A8;
         5'd1:    v = 32'h1DAC6705;
         5'd2:    v = 32'h0FADBAFC;
         5'd3:    v = 32'h07F56EA6;
         5'd4:    v = 32'h03FEAB76;
         5'd5:    v = 32'h01FFD55B;
         5'd6:    v = 32'h00FFFAAA;
         5'd7:    v = 32'h007FFF55;
         5'd8:    v = 32'h003FFFEA;
         5'd9:    v = 32'h001FFFFD;
         5'd10:   v = 32'h000FFFFF;
         5'd11:   v = 32'h0007FFFF;
         5'd12:   v = 32'h0003FFFF;
         5'd13:   v = 32'h0001FFFF;
         5'd14:   v = 32'h0000FFFF;
         5'd15:   v = 32'h00007FFF;
         5'd16:   v = 32'h00003FFF;
         5'd17:   v = 32'h00001FFF;
         5'd18:   v = 32'h00000FFF;
         5'd19:   v = 32'h000007FF;
         5'd20:   v = 32'h000003FF;
         5'd21:   v = 32'h000001FF;
         5'd22:   v = 32'h000000FF;
         5'd23:   v = 32'h0000007F;
         default: v = 32'h00000000;
      endcase
      return v[29:0];
   endfunction

endpackage

// ----- hw/rtl/unicycle_odometry_integrator_core.sv -----
// ----------------------------------------------------------------------------
// unicycle_odometry_integrator_core
// Dead-reckoning pose integrator with cordic heading rotation and smoothing.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  linear_speed, angular_speed
//  rsp      out        rsp_valid / rsp_stall  pos_x, pos_y, heading, smoothed x2
//  csr      in         csr_wr_en              csr_addr, csr_wr_data
//
//  each word runs in turn through the serial cordic rotator and the one
//  shared multiplier that forms heading, filter and position products;
//  req_stall holds off the next word until the sequencer is back in idle.
//  reset is synchronous and clears pose, filters and restores dt and alpha.
//  a finished word waits in the result register; a stalled result holds the
//  sequencer in its final step until the slot frees.
// ----------------------------------------------------------------------------
module unicycle_odometry_integrator_core import uoi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [15:0]    req_linear_speed,
   input  logic signed [15:0]    req_angular_speed,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_pos_x,
   output logic signed [31:0]    rsp_pos_y,
   output logic signed [15:0]    rsp_heading,
   output logic signed [15:0]    rsp_smoothed_linear,
   output logic signed [15:0]    rsp_smoothed_angular,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]           csr_wr_data
);

   uoi_cmd_type cmd;

   // sequencer
   uoi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic and state
   uoi_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_wr_en            (csr_wr_en),
      .csr_addr             (csr_addr),
      .csr_wr_data          (csr_wr_data),
      .req_linear_speed     (req_linear_speed),
      .req_angular_speed    (req_angular_speed),
      .rsp_pos_x            (rsp_pos_x),
      .rsp_pos_y            (rsp_pos_y),
      .rsp_heading          (rsp_heading),
      .rsp_smoothed_linear  (rsp_smoothed_linear),
      .rsp_smoothed_angular (rsp_smoothed_angular)
   );

endmodule

// ----- hw/rtl/uoi_datapath.sv -----
// ----------------------------------------------------------------------------
// uoi_datapath
// Pose and filter state, shared multiplier, cordic rotator and result word.
// ----------------------------------------------------------------------------
module uoi_datapath import uoi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  uoi_cmd_type           cmd,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]           csr_wr_data,
   input  logic signed [15:0]    req_linear_speed,
   input  logic signed [15:0]    req_angular_speed,
   output logic signed [31:0]    rsp_pos_x,
   output logic signed [31:0]    rsp_pos_y,
   output logic signed [15:0]    rsp_heading,
   output logic signed [15:0]    rsp_smoothed_linear,
   output logic signed [15:0]    rsp_smoothed_angular
);

   // configuration
   logic [15:0]        time_step_ff;
   logic [15:0]        alpha_ff;

   // captured command word
   logic signed [15:0] v_ff;
   logic signed [15:0] w_ff;

   // architectural state
   logic signed [31:0] x_ff;
   logic signed [31:0] y_ff;
   logic signed [15:0] heading_ff;
   logic signed [23:0] lin_f_ff;
   logic signed [23:0] ang_f_ff;

   // working registers
   logic signed [50:0] prod_ff;
   logic signed [50:0] lo_ff;
   logic signed [32:0] dist_ff;
   logic signed [33:0] cx_ff;
   logic signed [33:0] cy_ff;
   logic signed [33:0] cz_ff;
   logic               flip_ff;

   // result word
   logic signed [31:0] out_x_ff;
   logic signed [31:0] out_y_ff;
   logic signed [15:0] out_head_ff;
   logic signed [15:0] out_lin_ff;
   logic signed [15:0] out_ang_ff;

   // next values
   logic signed [50:0] prod_in;
   logic signed [15:0] heading_in;
   logic signed [23:0] lin_f_in;
   logic signed [23:0] ang_f_in;
   logic signed [31:0] x_in;
   logic signed [31:0] y_in;
   logic signed [33:0] cx_in;
   logic signed [33:0] cy_in;
   logic signed [33:0] cz_in;

   // one filter step from the rounded product
   function automatic logic signed [23:0] filt_next(input logic signed [23:0] f,
                                                    input logic signed [50:0] p);
      logic signed [41:0] rnd;
      logic signed [25:0] step;
      logic signed [26:0] sum;
      rnd  = p[41:0] + 42'sd32768;
      step = rnd[41:16];
      sum  = 27'(f) + 27'(step);
      if (sum > 27'sd8388607) begin
         sum = 27'sd8388607;
      end else if (sum < -27'sd8388608) begin
         sum = -27'sd8388608;
      end
      return sum[23:0];
   endfunction

   // combine the two partial products, round to Q16.16 and saturate
   function automatic logic signed [31:0] pos_next(input logic signed [31:0] acc,
                                                   input logic signed [50:0] hi,
                                                   input logic signed [50:0] lo);
      logic signed [67:0] full;
      logic signed [29:0] step;
      logic signed [32:0] sum;
      full = (68'(hi) <<< 16) + 68'(lo) + (68'sd1 <<< 37);
      step = full[67:38];
      sum  = 33'(acc) + 33'(step);
      if (sum > 33'sd2147483647) begin
         sum = 33'sd2147483647;
      end else if (sum < -33'sd2147483648) begin
         sum = -33'sd2147483648;
      end
      return sum[31:0];
   endfunction

   // shared multiplier operands
   logic signed [32:0] a_op;
   logic signed [17:0] b_op;
   logic signed [23:0] v_wide;
   logic signed [23:0] w_wide;
   logic signed [24:0] diff_lin;
   logic signed [24:0] diff_ang;
   logic signed [33:0] cos_v;
   logic signed [33:0] sin_v;

   assign v_wide   = {v_ff, 8'h00};
   assign w_wide   = {w_ff, 8'h00};
   assign diff_lin = 25'(v_wide) - 25'(lin_f_ff);
   assign diff_ang = 25'(w_wide) - 25'(ang_f_ff);
   assign cos_v    = flip_ff ? -cx_ff : cx_ff;
   assign sin_v    = flip_ff ? -cy_ff : cy_ff;

   always_comb begin
      a_op = '0;
      b_op = '0;
      case (cmd.mul_sel)
         MUL_HEAD: begin
            a_op = 33'(w_ff);
            b_op = {2'b00, time_step_ff};
         end
         MUL_DIST: begin
            a_op = 33'(v_ff);
            b_op = {2'b00, time_step_ff};
         end
         MUL_LIN: begin
            a_op = 33'(diff_lin);
            b_op = {2'b00, alpha_ff};
         end
         MUL_ANG: begin
            a_op = 33'(diff_ang);
            b_op = {2'b00, alpha_ff};
         end
         MUL_XLO: begin
            a_op = dist_ff;
            b_op = {2'b00, cos_v[15:0]};
         end
         MUL_XHI: begin
            a_op = dist_ff;
            b_op = cos_v[33:16];
         end
         MUL_YLO: begin
            a_op = dist_ff;
            b_op = {2'b00, sin_v[15:0]};
         end
         MUL_YHI: begin
            a_op = dist_ff;
            b_op = sin_v[33:16];
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
      prod_in = 51'(a_op) * 51'(b_op);
   end

   // heading step, single wrap and clamp into plus or minus pi
   logic signed [33:0] head_rnd;
   logic signed [22:0] head_step;
   logic signed [23:0] th0;
   logic signed [23:0] th1;
   logic signed [23:0] th2;

   always_comb begin
      head_rnd  = prod_ff[33:0] + 34'sd1024;
      head_step = head_rnd[33:11];
      th0       = 24'(heading_ff) + 24'(head_step);
      th1       = (th0 > 24'(PI_Q13)) ? th0 - 24'(TWO_PI_Q13) : th0;
      th2       = (th1 < -24'(PI_Q13)) ? th1 + 24'(TWO_PI_Q13) : th1;
      if (th2 > 24'(PI_Q13)) begin
         th2 = 24'(PI_Q13);
      end else if (th2 < -24'(PI_Q13)) begin
         th2 = -24'(PI_Q13);
      end
      heading_in = th2[15:0];
   end

   // filter and position updates
   assign lin_f_in = filt_next(lin_f_ff, prod_ff);
   assign ang_f_in = filt_next(ang_f_ff, prod_ff);
   assign x_in     = pos_next(x_ff, prod_ff, lo_ff);
   assign y_in     = pos_next(y_ff, prod_ff, lo_ff);

   // cordic start vector and one rotation step
   logic signed [16:0] ang_red;
   logic               flip_in;
   logic signed [33:0] atan_v;
   logic signed [33:0] dx;
   logic signed [33:0] dy;

   always_comb begin
      ang_red = 17'(heading_ff);
      flip_in = 1'b0;
      if (heading_ff > 16'(HALF_PI_Q13)) begin
         ang_red = 17'(heading_ff) - 17'(PI_Q13);
         flip_in = 1'b1;
      end else if (heading_ff < -16'(HALF_PI_Q13)) begin
         ang_red = 17'(heading_ff) + 17'(PI_Q13);
         flip_in = 1'b1;
      end
      atan_v = 34'(atan_q30(5'(cmd.iter)));
      dx     = cy_ff >>> cmd.iter;
      dy     = cx_ff >>> cmd.iter;
      if (!cz_ff[33]) begin
         cx_in = cx_ff - dx;
         cy_in = cy_ff + dy;
         cz_in = cz_ff - atan_v;
      end else begin
         cx_in = cx_ff + dx;
         cy_in = cy_ff - dy;
         cz_in = cz_ff + atan_v;
      end
   end

   // configuration and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         alpha_ff     <= SMOOTHING_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= '0;
         lin_f_ff     <= '0;
         ang_f_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_addr)
               REG_TIME_STEP: time_step_ff <= csr_wr_data;
               REG_SMOOTHING: alpha_ff     <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.head_upd) heading_ff <= heading_in;
         if (cmd.lin_upd)  lin_f_ff   <= lin_f_in;
         if (cmd.ang_upd)  ang_f_ff   <= ang_f_in;
         if (cmd.x_upd)    x_ff       <= x_in;
         if (cmd.y_upd)    y_ff       <= y_in;
      end
   end

   // working registers and result word
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         v_ff <= req_linear_speed;
         w_ff <= req_angular_speed;
      end
      if (cmd.mul_sel != MUL_NONE) prod_ff <= prod_in;
      if (cmd.lo_load)   lo_ff   <= prod_ff;
      if (cmd.dist_load) dist_ff <= prod_ff[32:0];
      if (cmd.cordic_init) begin
         cx_ff   <= 34'(CORDIC_GAIN);
         cy_ff   <= '0;
         cz_ff   <= {ang_red, 17'b0};
         flip_ff <= flip_in;
      end else if (cmd.cordic_step) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
      if (cmd.out_load) begin
         out_x_ff    <= x_ff;
         out_y_ff    <= y_ff;
         out_head_ff <= heading_ff;
         out_lin_ff  <= lin_f_ff[23:8];
         out_ang_ff  <= ang_f_ff[23:8];
      end
   end

   assign rsp_pos_x            = out_x_ff;
   assign rsp_pos_y            = out_y_ff;
   assign rsp_heading          = out_head_ff;
   assign rsp_smoothed_linear  = out_lin_ff;
   assign rsp_smoothed_angular = out_ang_ff;

   // heading stays wrapped after every update
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.head_upd) |-> (heading_ff <= 16'(PI_Q13)) && (heading_ff >= -16'(PI_Q13)))
      else $error("heading left the wrapped range");

   // the result word carries the heading held at the time of the load
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && !cmd.head_upd |=> rsp_heading == $past(heading_ff))
      else $error("result heading does not match state");

endmodule

// ----- hw/rtl/uoi_ctrl.sv -----
// ----------------------------------------------------------------------------
// uoi_ctrl
// Sequencer: steps the datapath through heading, filter, cordic and position.
// ----------------------------------------------------------------------------
module uoi_ctrl import uoi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output uoi_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_HEAD,
      S_HEAD,
      S_CINIT,
      S_CITER,
      S_XLO,
      S_XHI,
      S_XUPD,
      S_YHI,
      S_YUPD,
      S_DONE
   } state_type;

   localparam logic [IDX_W-1:0] ITER_LAST = IDX_W'(CORDIC_ITERS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] iter_ff, iter_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode and next state
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_NONE;
      cmd.iter     = iter_ff;
      state_in     = state_ff;
      iter_in      = iter_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MUL_HEAD;
            end
         end
         S_MUL_HEAD: begin
            cmd.mul_sel = MUL_HEAD;
            state_in    = S_HEAD;
         end
         S_HEAD: begin
            cmd.head_upd = 1'b1;
            cmd.mul_sel  = MUL_LIN;
            state_in     = S_CINIT;
         end
         S_CINIT: begin
            cmd.cordic_init = 1'b1;
            cmd.lin_upd     = 1'b1;
            cmd.mul_sel     = MUL_ANG;
            iter_in         = '0;
            state_in        = S_CITER;
         end
         S_CITER: begin
            cmd.cordic_step = 1'b1;
            // filter and distance work rides along the first two rotations
            if (iter_ff == '0) begin
               cmd.ang_upd = 1'b1;
               cmd.mul_sel = MUL_DIST;
            end
            if (iter_ff == IDX_W'(1)) begin
               cmd.dist_load = 1'b1;
            end
            if (iter_ff == ITER_LAST) begin
               state_in = S_XLO;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         S_XLO: begin
            cmd.mul_sel = MUL_XLO;
            state_in    = S_XHI;
         end
         S_XHI: begin
            cmd.lo_load = 1'b1;
            cmd.mul_sel = MUL_XHI;
            state_in    = S_XUPD;
         end
         S_XUPD: begin
            cmd.x_upd   = 1'b1;
            cmd.mul_sel = MUL_YLO;
            state_in    = S_YHI;
         end
         S_YHI: begin
            cmd.lo_load = 1'b1;
            cmd.mul_sel = MUL_YHI;
            state_in    = S_YUPD;
         end
         S_YUPD: begin
            cmd.y_upd = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // result word handshake
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // never overwrite a word that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result word overwritten while stalled");

   // an accepted word starts the heading multiply next
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_MUL_HEAD)
      else $error("accepted word did not start the sequence");

   // the rotator leaves after its last iteration
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CITER && iter_ff == ITER_LAST |=> state_ff == S_XLO)
      else $error("cordic iteration count overrun");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the unicycle odometry integrator core. A queue of
// velocity commands feeds a bursty driver and a stalling receiver checks each
// pose word against a bit-exact fixed point model held in the bench.
// ----------------------------------------------------------------------------
module testbench;
   import uoi_pkg::*;

   // bench timing
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_AT       = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_CAP    = 50;

   // fixed point constants of the integrator
   localparam longint HEAD_PI      = 25736;
   localparam longint HEAD_TWO_PI  = 51472;
   localparam longint HEAD_HALF_PI = 12868;
   localparam longint ROT_GAIN     = 652032874;
   localparam int     ROT_STEPS    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam longint POS_MAX      = 2147483647;
   localparam longint POS_MIN      = -POS_MAX - 1;
   localparam longint FILT_MAX     = 8388607;
   localparam longint FILT_MIN     = -8388608;
   localparam logic [15:0] DT_DEFAULT    = 16'd3277;
   localparam logic [15:0] ALPHA_DEFAULT = 16'd6554;

   // register indexes with no register behind them
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_B = 2'd3;

   typedef struct packed {
      logic signed [15:0] lin;
      logic signed [15:0] ang;
   } speed_cmd_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic signed [15:0] lin;
      logic signed [15:0] ang;
   } pose_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [15:0]    req_linear_speed = '0;
   logic signed [15:0]    req_angular_speed = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [31:0]    rsp_pos_x;
   logic signed [31:0]    rsp_pos_y;
   logic signed [15:0]    rsp_heading;
   logic signed [15:0]    rsp_smoothed_linear;
   logic signed [15:0]    rsp_smoothed_angular;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [15:0]           csr_wr_data = '0;

   unicycle_odometry_integrator_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_linear_speed     (req_linear_speed),
      .req_angular_speed    (req_angular_speed),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pos_x            (rsp_pos_x),
      .rsp_pos_y            (rsp_pos_y),
      .rsp_heading          (rsp_heading),
      .rsp_smoothed_linear  (rsp_smoothed_linear),
      .rsp_smoothed_angular (rsp_smoothed_angular),
      .csr_wr_en            (csr_wr_en),
      .csr_addr             (csr_addr),
      .csr_wr_data          (csr_wr_data)
   );

   // bench state
   speed_cmd_type  pending_cmds[$];
   pose_word_type  expected_poses[$];
   int          err_count = 0;
   int          rsp_count = 0;
   int          quiet_cycles = 0;
   int          burst_left = 4;
   int          gap_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          rx_phase = 0;
   logic        req_taken = 1'b0;

   // model copy of the registers and the integrator state
   logic [15:0] step_q16 = DT_DEFAULT;
   logic [15:0] alpha_q16 = ALPHA_DEFAULT;
   longint      x_st = 0;
   longint      y_st = 0;
   longint      head_st = 0;
   longint      lin_st = 0;
   longint      ang_st = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // fixed point model
   // ------------------------------------------------------------------------

   // round half up, then arithmetic shift
   function automatic longint rnd_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // arctangent of 2^-i in Q2.30
   function automatic longint arctan_q30(input int i);
      case (i)
         0:  return 64'h3243F6A8;
         1:  return 64'h1DAC6705;
         2:  return 64'h0FADBAFC;
         3:  return 64'h07F56EA6;
         4:  return 64'h03FEAB76;
         5:  return 64'h01FFD55B;
         6:  return 64'h00FFFAAA;
         7:  return 64'h007FFF55;
         8:  return 64'h003FFFEA;
         9:  return 64'h001FFFFD;
         10: return 64'h000FFFFF;
         11: return 64'h0007FFFF;
         12: return 64'h0003FFFF;
         13: return 64'h0001FFFF;
         14: return 64'h0000FFFF;
         15: return 64'h00007FFF;
         16: return 64'h00003FFF;
         17: return 64'h00001FFF;
         18: return 64'h00000FFF;
         19: return 64'h000007FF;
         20: return 64'h000003FF;
         21: return 64'h000001FF;
         22: return 64'h000000FF;
         23: return 64'h0000007F;
         default: return 0;
      endcase
   endfunction

   // rotation-mode cordic, angle in Q3.13, cos and sin in Q2.30
   function automatic void rotate(input longint ang, output longint c, output longint s);
      longint xr, yr, zr, dx, dy;
      bit     flip;
      xr = ROT_GAIN;
      yr = 0;
      flip = 1'b0;
      // fold outer half turns onto the inner one
      if (ang > HEAD_HALF_PI) begin
         ang = ang - HEAD_PI;
         flip = 1'b1;
      end else if (ang < -HEAD_HALF_PI) begin
         ang = ang + HEAD_PI;
         flip = 1'b1;
      end
      zr = ang * 131072;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = yr >>> i;
         dy = xr >>> i;
         if (zr >= 0) begin
            xr = xr - dx;
            yr = yr + dy;
            zr = zr - arctan_q30(i);
         end else begin
            xr = xr + dx;
            yr = yr - dy;
            zr = zr + arctan_q30(i);
         end
      end
      c = flip ? -xr : xr;
      s = flip ? -yr : yr;
   endfunction

   // first-order smoothing in Q8.16
   function automatic longint smooth(input longint f, input longint v_q8);
      longint diff;
      diff = v_q8 * 256 - f;
      f = f + rnd_shift(longint'(alpha_q16) * diff, 16);
      return clamp_to(f, FILT_MIN, FILT_MAX);
   endfunction

   // one euler step of the pose, returns the word the core should emit
   function automatic pose_word_type advance_pose(input logic signed [15:0] lin_cmd,
                                                  input logic signed [15:0] ang_cmd);
      longint        v, w, th, c, s, travel, tmp;
      pose_word_type p;
      v = lin_cmd;
      w = ang_cmd;
      // heading step, single wrap, then clamp what is still out of range
      th = head_st + rnd_shift(longint'(step_q16) * w, 11);
      if (th > HEAD_PI) th = th - HEAD_TWO_PI;
      if (th < -HEAD_PI) th = th + HEAD_TWO_PI;
      head_st = clamp_to(th, -HEAD_PI, HEAD_PI);
      // position along the new heading, saturating
      rotate(head_st, c, s);
      travel = longint'(step_q16) * v;
      x_st = clamp_to(x_st + rnd_shift(travel * c, 38), POS_MIN, POS_MAX);
      y_st = clamp_to(y_st + rnd_shift(travel * s, 38), POS_MIN, POS_MAX);
      lin_st = smooth(lin_st, v);
      ang_st = smooth(ang_st, w);
      p.pos_x = x_st[31:0];
      p.pos_y = y_st[31:0];
      p.heading = head_st[15:0];
      tmp = lin_st >>> 8;
      p.lin = tmp[15:0];
      tmp = ang_st >>> 8;
      p.ang = tmp[15:0];
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         if (err_count < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         err_count++;
      end
   endtask

   // sample at the rising edge: registers, accepted commands, accepted poses
   always @(posedge clock) begin : watch
      pose_word_type want;
      if (reset) begin
         step_q16 = DT_DEFAULT;
         alpha_q16 = ALPHA_DEFAULT;
         x_st = 0;
         y_st = 0;
         head_st = 0;
         lin_st = 0;
         ang_st = 0;
         req_taken <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               REG_TIME_STEP: step_q16 = csr_wr_data;
               REG_SMOOTHING: alpha_q16 = csr_wr_data;
               default: ;
            endcase
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_poses.push_back(advance_pose(req_linear_speed, req_angular_speed));
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_poses.size() == 0) begin
               if (err_count < REPORT_CAP)
                  $display("%0t: unexpected pose word, expected none, got x %0d y %0d",
                           $time, rsp_pos_x, rsp_pos_y);
               err_count++;
            end else begin
               want = expected_poses.pop_front();
               check_field("pos_x", want.pos_x, rsp_pos_x);
               check_field("pos_y", want.pos_y, rsp_pos_y);
               check_field("heading", want.heading, rsp_heading);
               check_field("smoothed_linear", want.lin, rsp_smoothed_linear);
               check_field("smoothed_angular", want.ang, rsp_smoothed_angular);
            end
         end
      end
   end

   // no word moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: timeout, %0d pose words outstanding", $time, expected_poses.size());
         $display("unicycle_odometry_integrator_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------------

   // command driver: bursts of random length, random gaps between them
   always @(negedge clock) begin : feed
      logic          nv;
      speed_cmd_type nxt;
      nv = req_valid;
      nxt.lin = req_linear_speed;
      nxt.ang = req_angular_speed;
      if (reset) begin
         nv = 1'b0;
      end else if (req_valid && !req_taken) begin
         nv = 1'b1;
      end else if (gap_left > 0) begin
         nv = 1'b0;
         gap_left--;
      end else if (pending_cmds.size() > 0) begin
         nxt = pending_cmds.pop_front();
         nv = 1'b1;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         end
      end else begin
         nv = 1'b0;
      end
      req_valid <= nv;
      req_linear_speed <= nxt.lin;
      req_angular_speed <= nxt.ang;
   end

   // receiver stall pattern, stepping through eight phases, plus one long hold-off
   always @(negedge clock) begin : drain
      logic st;
      st = 1'b0;
      if (!reset) begin
         if (!hold_done && rsp_count >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            st = 1'b1;
            hold_left--;
         end else begin
            rx_phase++;
            case ((rx_phase >> 6) % 8)
               0, 1:    st = 1'b0;
               2:       st = ($urandom_range(0, 3) == 0);
               3:       st = ($urandom_range(0, 1) == 0);
               4:       st = ($urandom_range(0, 3) != 0);
               5:       st = rx_phase[3];
               default: st = ($urandom_range(0, 6) == 0);
            endcase
         end
      end
      rsp_stall <= st;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   task automatic queue_cmd(input logic signed [15:0] lin, input logic signed [15:0] ang);
      speed_cmd_type c;
      c.lin = lin;
      c.ang = ang;
      pending_cmds.push_back(c);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every command has gone in and every pose word has come out
   task automatic settle();
      while (pending_cmds.size() != 0 || req_valid || expected_poses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mix of full range, small, extreme and unit speeds
   function automatic logic signed [15:0] pick_speed();
      logic signed [15:0] t;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: t = 16'($urandom);
         4, 5, 6: begin
            t = 16'($urandom_range(0, 1023));
            t = t - 16'sd512;
         end
         7:       t = 16'sh7FFF;
         8:       t = 16'sh8000;
         default: t = $urandom_range(0, 1) ? 16'sh0001 : 16'shFFFF;
      endcase
      return t;
   endfunction

   initial begin : run
      logic signed [15:0] lv, av;
      int                 n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults after reset: zero, extremes, units and alternating bits
      queue_cmd(16'sh0000, 16'sh0000);
      queue_cmd(16'sh7FFF, 16'sh0000);
      queue_cmd(16'sh8000, 16'sh0000);
      queue_cmd(16'sh0000, 16'sh7FFF);
      queue_cmd(16'sh0000, 16'sh8000);
      queue_cmd(16'sh7FFF, 16'sh7FFF);
      queue_cmd(16'sh8000, 16'sh8000);
      queue_cmd(16'shFFFF, 16'shFFFF);
      queue_cmd(16'sh0001, 16'sh0001);
      queue_cmd(16'sh5555, 16'shAAAA);
      queue_cmd(16'shAAAA, 16'sh5555);
      queue_cmd(16'sh0100, 16'sh0100);
      settle();

      // largest dt and alpha: heading far out of range clamps to either bound;
      // writes to spare indexes must change nothing
      write_reg(REG_TIME_STEP, 16'hFFFF);
      write_reg(REG_SMOOTHING, 16'hFFFF);
      write_reg(REG_SPARE_A, 16'h0001);
      write_reg(REG_SPARE_B, 16'h1234);
      queue_cmd(16'sh0000, 16'sh7FFF);
      queue_cmd(16'sh7FFF, 16'sh0000);
      queue_cmd(16'sh0000, 16'sh8000);
      queue_cmd(16'sh8000, 16'sh0000);
      queue_cmd(16'sh7FFF, 16'sh7FFF);
      queue_cmd(16'sh8000, 16'sh8000);
      queue_cmd(16'sh0064, 16'sh03E8);
      queue_cmd(16'shFF00, 16'sh0200);
      settle();

      // zero dt and alpha: pose and filters frozen
      write_reg(REG_TIME_STEP, 16'h0000);
      write_reg(REG_SMOOTHING, 16'h0000);
      queue_cmd(16'sh7FFF, 16'sh7FFF);
      queue_cmd(16'sh8000, 16'sh8000);
      queue_cmd(16'sh1234, 16'shEDCB);
      queue_cmd(16'sh0000, 16'sh0000);
      settle();

      // full speed along a clamped heading of pi until x saturates
      write_reg(REG_TIME_STEP, 16'hFFFF);
      write_reg(REG_SMOOTHING, 16'($urandom));
      queue_cmd(16'sh7FFF, 16'sh7FFF);
      for (int i = 0; i < 299; i++) begin
         lv = 16'($urandom_range(30000, 32767));
         queue_cmd(lv, 16'sh0000);
      end
      settle();

      // random commands under several register settings
      for (int k = 0; k < 3; k++) begin
         case (k)
            0: begin
               write_reg(REG_TIME_STEP, 16'($urandom_range(1, 8000)));
               write_reg(REG_SMOOTHING, 16'($urandom));
            end
            1: begin
               write_reg(REG_TIME_STEP, 16'($urandom));
               write_reg(REG_SMOOTHING, 16'($urandom_range(0, 1000)));
               write_reg(REG_SPARE_A, 16'($urandom));
               write_reg(REG_SPARE_B, 16'($urandom));
            end
            default: begin
               write_reg(REG_TIME_STEP, 16'h0001);
               write_reg(REG_SMOOTHING, 16'h0001);
            end
         endcase
         n = 0;
         while (n < 130) begin
            lv = pick_speed();
            av = pick_speed();
            // a held command lets the filters settle
            if ($urandom_range(0, 9) == 0) begin
               repeat (5) queue_cmd(lv, av);
               n += 5;
            end else begin
               queue_cmd(lv, av);
               n++;
            end
         end
         settle();
      end

      if (err_count == 0)
         $display("unicycle_odometry_integrator_core regression: pass");
      else
         $display("unicycle_odometry_integrator_core regression: fail");
      $finish;
   end

endmodule
